/* hw/rtl/wcss_pkg.sv */
// Shared types, constants and helpers for the weighted channel send scheduler.
// No dependencies; used by wcss_cell and weighted_channel_send_scheduler.
`default_nettype none

package wcss_pkg;

  // Field and storage widths
  localparam int unsigned CountW      = 32;
  localparam int unsigned PrioW       = 8;
  localparam int unsigned ChW         = 3;
  localparam int unsigned BytesW      = 16;
  localparam int unsigned KindW       = 2;
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned CfgW        = MaxChannels * PrioW;

  // Decay by 8/10 = 4/5: long division by five, one digit of DigitW bits a cycle
  localparam int unsigned DecayDen = 5;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned DivSteps = CountW / DigitW;
  localparam int unsigned RemW     = 3;

  // Step counter covers both the arbitration walk and the division digits
  localparam int unsigned StepW = 3;

  localparam logic [CountW-1:0] CountMax = '1;

  // Item kinds
  typedef enum logic [KindW-1:0] {
    KIND_ARB    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_DECAY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Best candidate so far, handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [ChW-1:0]    ch;
    logic [PrioW-1:0]  prio;
    logic [CountW-1:0] count;
  } cand_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic              rep_en;
    logic [BytesW-1:0] bytes;
    logic              div_en;
    logic              div_first;
    logic              div_last;
  } cell_ctrl_t;

  // floor(4 * r / 5) for a remainder r of division by five
  function automatic logic [1:0] decay_frac(input logic [RemW-1:0] rem);
    logic [1:0] res;
    case (rem)
      3'd2:    res = 2'd1;
      3'd3:    res = 2'd2;
      3'd4:    res = 2'd3;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/wcss_cell.sv */
// One channel cell: holds the sent-byte count, applies reports and decay,
// and passes the best arbitration candidate on to its neighbour. Uses wcss_pkg.
`default_nettype none

module wcss_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  wcss_pkg::cell_ctrl_t      ctrl_i,
  input  wire                             rep_sel_i,
  input  wire                             pend_i,
  input  wire  [wcss_pkg::PrioW-1:0]      prio_i,
  input  wire  [wcss_pkg::ChW-1:0]        chan_i,
  input  wire  wcss_pkg::cand_t           cand_i,
  output wcss_pkg::cand_t                 cand_o
);

  localparam int unsigned ProdW = wcss_pkg::CountW + wcss_pkg::PrioW;

  logic [wcss_pkg::CountW-1:0] count_q, count_d;
  logic [wcss_pkg::RemW-1:0]   rem_q, rem_d;
  wcss_pkg::cand_t             cand_q, cand_d;

  logic [ProdW-1:0]            lhs, rhs;
  logic                        eligible, take;

  // Division step: one DigitW-bit digit of long division by five, MSB first
  always_comb begin
    logic [wcss_pkg::RemW-1:0]   rem;
    logic [wcss_pkg::RemW:0]     trial;
    logic [wcss_pkg::DigitW-1:0] qbits;
    logic [wcss_pkg::CountW-1:0] qnew;
    logic [wcss_pkg::CountW:0]   sum;
    rem   = ctrl_i.div_first ? '0 : rem_q;
    qbits = '0;
    for (int i = 0; i < int'(wcss_pkg::DigitW); i++) begin
      trial = {rem, count_q[wcss_pkg::CountW-1-i]};
      if (trial >= (wcss_pkg::RemW+1)'(wcss_pkg::DecayDen)) begin
        qbits[wcss_pkg::DigitW-1-i] = 1'b1;
        rem = wcss_pkg::RemW'(trial - (wcss_pkg::RemW+1)'(wcss_pkg::DecayDen));
      end else begin
        rem = trial[wcss_pkg::RemW-1:0];
      end
    end
    qnew = {count_q[wcss_pkg::CountW-wcss_pkg::DigitW-1:0], qbits};
    sum  = {1'b0, count_q} + (wcss_pkg::CountW+1)'(ctrl_i.bytes);

    rem_d   = rem_q;
    count_d = count_q;
    if (ctrl_i.div_en) begin
      rem_d = rem;
      // last digit: count = 4 * (count / 5) + floor(4 * rem / 5)
      if (ctrl_i.div_last) begin
        count_d = {qnew[wcss_pkg::CountW-3:0], wcss_pkg::decay_frac(rem)};
      end else begin
        count_d = qnew;
      end
    end else if (ctrl_i.rep_en && rep_sel_i) begin
      count_d = sum[wcss_pkg::CountW] ? wcss_pkg::CountMax : sum[wcss_pkg::CountW-1:0];
    end
  end

  // Arbitration: count/prio < best_count/best_prio by cross multiplication
  assign lhs      = count_q * cand_i.prio;
  assign rhs      = cand_i.count * prio_i;
  assign eligible = pend_i && (prio_i != '0);
  assign take     = eligible && (!cand_i.found || (lhs < rhs));

  always_comb begin
    cand_d = cand_i;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.ch    = chan_i;
      cand_d.prio  = prio_i;
      cand_d.count = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rem_q   <= '0;
      cand_q  <= '0;
    end else begin
      count_q <= count_d;
      rem_q   <= rem_d;
      cand_q  <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

`default_nettype wire

/* hw/rtl/weighted_channel_send_scheduler.sv */
// Arbitrate: the candidate walks one cell a cycle down the chain, and the result word
// is loaded once it has passed every cell. A new word is taken only after that load.
// Sent report: the addressed cell adds the bytes. Decay tick: every cell runs the
// 4-bit-a-cycle division by five. Unused kind: goes straight to the result word.
// Asynchronous active-low reset clears all counts, the priority table and the control.
// Top level: control sequencer, output register and the chain of channel cells.
`default_nettype none

module weighted_channel_send_scheduler #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [wcss_pkg::CfgW-1:0]        cfg_data_i,
  // input words
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [wcss_pkg::KindW-1:0]       kind_i,
  input  wire  [wcss_pkg::MaxChannels-1:0] pending_mask_i,
  input  wire  [wcss_pkg::ChW-1:0]         report_channel_i,
  input  wire  [wcss_pkg::BytesW-1:0]      bytes_sent_i,
  // result words
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             granted_o,
  output logic [wcss_pkg::ChW-1:0]         grant_channel_o
);

  localparam logic [wcss_pkg::StepW-1:0] ArbLast = wcss_pkg::StepW'(NUM_CHANNELS - 1);
  localparam logic [wcss_pkg::StepW-1:0] DivLast = wcss_pkg::StepW'(wcss_pkg::DivSteps - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARB,
    S_REPORT,
    S_DECAY,
    S_RES
  } state_e;

  state_e                           state_q;
  logic [wcss_pkg::StepW-1:0]       cnt_q;
  wcss_pkg::kind_e                  kind_q;
  logic [wcss_pkg::MaxChannels-1:0] pend_q;
  logic [wcss_pkg::ChW-1:0]         rch_q;
  logic [wcss_pkg::BytesW-1:0]      bytes_q;
  logic                             out_valid_q;
  logic                             granted_q;
  logic [wcss_pkg::ChW-1:0]         grant_ch_q;
  logic [wcss_pkg::CfgW-1:0]        prio_q;

  wcss_pkg::cell_ctrl_t             ctrl;
  wcss_pkg::cand_t                  chain [NUM_CHANNELS+1];
  logic                             res_grant;

  // Priority table register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= '0;
    end else if (cfg_valid_i) begin
      prio_q <= cfg_data_i;
    end
  end

  // Commands to the cells
  always_comb begin
    ctrl.rep_en    = (state_q == S_REPORT);
    ctrl.bytes     = bytes_q;
    ctrl.div_en    = (state_q == S_DECAY);
    ctrl.div_first = (cnt_q == '0);
    ctrl.div_last  = (cnt_q == DivLast);
  end

  // Chain of cells, candidate enters empty at the head
  assign chain[0] = '0;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_cell
    wcss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .rep_sel_i (rch_q == wcss_pkg::ChW'(c)),
      .pend_i    (pend_q[c]),
      .prio_i    (prio_q[c*wcss_pkg::PrioW +: wcss_pkg::PrioW]),
      .chan_i    (wcss_pkg::ChW'(c)),
      .cand_i    (chain[c]),
      .cand_o    (chain[c+1])
    );
  end

  assign res_grant = (kind_q == wcss_pkg::KIND_ARB) && chain[NUM_CHANNELS].found;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      kind_q      <= wcss_pkg::KIND_NONE;
      pend_q      <= '0;
      rch_q       <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
      granted_q   <= 1'b0;
      grant_ch_q  <= '0;
    end else begin
      // result taken; in the result state the reload below decides
      if (out_valid_q && out_ready_i && (state_q != S_RES)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= wcss_pkg::kind_e'(kind_i);
            pend_q  <= pending_mask_i;
            rch_q   <= report_channel_i;
            bytes_q <= bytes_sent_i;
            cnt_q   <= '0;
            unique case (wcss_pkg::kind_e'(kind_i))
              wcss_pkg::KIND_ARB:    state_q <= S_ARB;
              wcss_pkg::KIND_REPORT: state_q <= S_REPORT;
              wcss_pkg::KIND_DECAY:  state_q <= S_DECAY;
              default:               state_q <= S_RES;
            endcase
          end
        end
        S_ARB: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ArbLast) begin
            state_q <= S_RES;
          end
        end
        S_REPORT: begin
          state_q <= S_RES;
        end
        S_DECAY: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            state_q <= S_RES;
          end
        end
        S_RES: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            granted_q   <= res_grant;
            grant_ch_q  <= res_grant ? chain[NUM_CHANNELS].ch : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign grant_channel_o = grant_ch_q;

  // Checks
  a_grant_prio_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |->
      prio_q[grant_channel_o*wcss_pkg::PrioW +: wcss_pkg::PrioW] != '0)
    else $error("grant to a channel with zero priority");

  a_nogrant_zero_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> grant_channel_o == '0)
    else $error("channel not zero without a grant");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |-> 32'(grant_channel_o) < NUM_CHANNELS)
    else $error("grant to a channel beyond the chain");

  a_grant_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && granted_o |-> pend_q[grant_channel_o])
    else $error("grant to a channel with nothing pending");

  a_load_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_RES)
    else $error("result word loaded outside the result state");

endmodule

`default_nettype wire

/* tb/tb_weighted_channel_send_scheduler.sv */
// Self-checking testbench for weighted_channel_send_scheduler: a directed table,
// a long run of full-size reports, then random words under several idling patterns.
// Depends on wcss_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module tb_weighted_channel_send_scheduler;

  localparam int unsigned NumCh      = 8;
  localparam int unsigned DrainCycles = 24;       // longer than the decay word
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned PhaseWords  = 350;

  typedef struct packed {
    logic                     granted;
    logic [wcss_pkg::ChW-1:0] chan;
  } grant_t;

  // One row of the directed table: either a priority write or a word, repeated
  typedef struct packed {
    logic                        is_cfg;
    logic [wcss_pkg::CfgW-1:0]   cfg_word;
    wcss_pkg::kind_e             kind;
    logic [7:0]                  mask;
    logic [wcss_pkg::ChW-1:0]    chan;
    logic [wcss_pkg::BytesW-1:0] nbytes;
    logic [16:0]                 reps;
    logic                        no_grant;  // result known at a glance: nothing granted
  } plan_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [wcss_pkg::CfgW-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [wcss_pkg::KindW-1:0]       kind = '0;
  logic [wcss_pkg::MaxChannels-1:0] pending_mask = '0;
  logic [wcss_pkg::ChW-1:0]         report_channel = '0;
  logic [wcss_pkg::BytesW-1:0]      bytes_sent = '0;
  logic                             out_valid;
  logic                             rx_ready = 1'b0;
  logic                             granted;
  logic [wcss_pkg::ChW-1:0]         grant_channel;

  // Predictor state
  logic [wcss_pkg::CfgW-1:0]   prio_table = '0;
  logic [wcss_pkg::CountW-1:0] sent_tally [NumCh];

  grant_t    grants_due [$];
  plan_row_t plan [$];
  grant_t    due;
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        holds_asked = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  logic [wcss_pkg::CfgW-1:0] phase_prio;

  weighted_channel_send_scheduler #(
    .NUM_CHANNELS(NumCh)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind),
    .pending_mask_i  (pending_mask),
    .report_channel_i(report_channel),
    .bytes_sent_i    (bytes_sent),
    .out_valid_o     (out_valid),
    .out_ready_i     (rx_ready),
    .granted_o       (granted),
    .grant_channel_o (grant_channel)
  );

  always #5 clk_i = ~clk_i;

  // Expected result of one word; also advances the count state
  function automatic grant_t predict_grant(input wcss_pkg::kind_e k, input logic [7:0] m,
                                           input logic [wcss_pkg::ChW-1:0] c,
                                           input logic [wcss_pkg::BytesW-1:0] b);
    grant_t      res;
    bit          found;
    int          best;
    logic [7:0]  p;
    logic [7:0]  bp;
    logic [39:0] lhs;
    logic [39:0] rhs;
    logic [32:0] sum;
    res = '0;
    found = 0;
    best = 0;
    case (k)
      wcss_pkg::KIND_ARB: begin
        for (int ch = 0; ch < NumCh; ch++) begin
          p = prio_table[8*ch +: 8];
          if (m[ch] && p != 0) begin
            if (!found) begin
              found = 1;
              best = ch;
            end else begin
              // ratio compare by cross multiplication, strict so ties keep the lower channel
              bp  = prio_table[8*best +: 8];
              lhs = 40'(sent_tally[ch]) * 40'(bp);
              rhs = 40'(sent_tally[best]) * 40'(p);
              if (lhs < rhs) best = ch;
            end
          end
        end
      end
      wcss_pkg::KIND_REPORT: begin
        if (int'(c) < NumCh) begin
          sum = 33'(sent_tally[c]) + 33'(b);
          sent_tally[c] = sum[32] ? wcss_pkg::CountMax : sum[wcss_pkg::CountW-1:0];
        end
      end
      wcss_pkg::KIND_DECAY: begin
        for (int ch = 0; ch < NumCh; ch++)
          sent_tally[ch] = 32'((64'(sent_tally[ch]) * 64'd8) / 64'd10);
      end
      default: ;
    endcase
    res.granted = found;
    res.chan    = found ? 3'(best) : '0;
    return res;
  endfunction

  function automatic void plan_word(input wcss_pkg::kind_e k, input logic [7:0] m,
                                    input logic [wcss_pkg::ChW-1:0] c,
                                    input logic [wcss_pkg::BytesW-1:0] b,
                                    input int n, input bit nothing);
    plan_row_t row;
    row          = '0;
    row.kind     = k;
    row.mask     = m;
    row.chan     = c;
    row.nbytes   = b;
    row.reps     = 17'(n);
    row.no_grant = nothing;
    plan.push_back(row);
  endfunction

  function automatic void plan_prio(input logic [wcss_pkg::CfgW-1:0] v);
    plan_row_t row;
    row          = '0;
    row.is_cfg   = 1'b1;
    row.cfg_word = v;
    plan.push_back(row);
  endfunction

  // Offer one word, with a random gap first; record its expectation on acceptance
  task automatic send_word(input wcss_pkg::kind_e k, input logic [7:0] m,
                           input logic [wcss_pkg::ChW-1:0] c,
                           input logic [wcss_pkg::BytesW-1:0] b, input bit nothing);
    grant_t g;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    pending_mask   <= m;
    report_channel <= c;
    bytes_sent     <= b;
    do @(posedge clk_i); while (!in_ready);
    g = predict_grant(k, m, c, b);
    if (nothing) g = '0;
    grants_due.push_back(g);
  endtask

  // Priorities change only once the block has drained
  task automatic write_priorities(input logic [wcss_pkg::CfgW-1:0] v);
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    prio_table = v;
  endtask

  task automatic random_word();
    int                          sel;
    wcss_pkg::kind_e             k;
    logic [7:0]                  m;
    logic [wcss_pkg::ChW-1:0]    c;
    logic [wcss_pkg::BytesW-1:0] b;
    sel = $urandom_range(99);
    if (sel < 45)      k = wcss_pkg::KIND_ARB;
    else if (sel < 80) k = wcss_pkg::KIND_REPORT;
    else if (sel < 92) k = wcss_pkg::KIND_DECAY;
    else               k = wcss_pkg::KIND_NONE;
    case ($urandom_range(3))
      0:       m = 8'hFF;
      1:       m = 8'(1 << $urandom_range(7));
      default: m = 8'($urandom);
    endcase
    c = 3'($urandom);
    case ($urandom_range(3))
      0:       b = 16'($urandom_range(255));
      1:       b = 16'hFFFF;
      default: b = 16'($urandom);
    endcase
    send_word(k, m, c, b, 1'b0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      rx_ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      rx_ready     <= 1'b0;
      hold_left    <= HoldCycles;
      holds_served <= holds_served + 1;
    end else begin
      rx_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (out_valid && rx_ready) begin
      if (grants_due.size() == 0) begin
        $display("%0t: result word with none outstanding: granted %0d channel %0d",
                 $time, granted, grant_channel);
        mismatches++;
      end else begin
        due = grants_due.pop_front();
        if (granted !== due.granted) begin
          $display("%0t: granted expected %0d actual %0d", $time, due.granted, granted);
          mismatches++;
        end
        if (grant_channel !== due.chan) begin
          $display("%0t: grant_channel expected %0d actual %0d",
                   $time, due.chan, grant_channel);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("weighted_channel_send_scheduler verification failed");
    $finish;
  end

  initial begin
    for (int ch = 0; ch < NumCh; ch++) sent_tally[ch] = '0;

    // Directed table
    plan_word(wcss_pkg::KIND_ARB,    8'hFF, 3'd0, 16'h0000, 1, 1'b1);  // priorities all zero
    plan_word(wcss_pkg::KIND_ARB,    8'h00, 3'd0, 16'h0000, 1, 1'b1);
    plan_word(wcss_pkg::KIND_NONE,   8'hFF, 3'd7, 16'hFFFF, 1, 1'b1);  // unused kind ignored
    plan_prio(64'h0000_0000_0000_0201);
    plan_word(wcss_pkg::KIND_ARB,    8'h03, 3'd0, 16'h0000, 1, 1'b0);  // both zero: lower wins
    plan_word(wcss_pkg::KIND_REPORT, 8'h00, 3'd0, 16'd1000, 1, 1'b1);
    plan_word(wcss_pkg::KIND_REPORT, 8'hFF, 3'd1, 16'd2000, 1, 1'b1);
    plan_word(wcss_pkg::KIND_ARB,    8'h03, 3'd0, 16'h0000, 1, 1'b0);  // 1000/1 equals 2000/2
    plan_word(wcss_pkg::KIND_ARB,    8'h02, 3'd0, 16'h0000, 1, 1'b0);
    plan_word(wcss_pkg::KIND_ARB,    8'hFC, 3'd0, 16'h0000, 1, 1'b1);  // zero-priority only
    plan_word(wcss_pkg::KIND_DECAY,  8'h00, 3'd0, 16'h0000, 1, 1'b1);
    plan_word(wcss_pkg::KIND_ARB,    8'h03, 3'd0, 16'h0000, 1, 1'b0);  // still tied after decay
    plan_word(wcss_pkg::KIND_REPORT, 8'h00, 3'd0, 16'd1,    1, 1'b1);
    plan_word(wcss_pkg::KIND_ARB,    8'h03, 3'd0, 16'h0000, 1, 1'b0);
    plan_prio('1);
    plan_word(wcss_pkg::KIND_ARB,    8'h80, 3'd0, 16'h0000, 1, 1'b0);
    plan_word(wcss_pkg::KIND_ARB,    8'hFF, 3'd0, 16'h0000, 1, 1'b0);
    // a run of full-size reports builds one large count
    plan_word(wcss_pkg::KIND_REPORT, 8'h00, 3'd5, 16'hFFFF, 200, 1'b1);
    plan_word(wcss_pkg::KIND_REPORT, 8'h00, 3'd5, 16'hFFFF, 1, 1'b1);
    plan_word(wcss_pkg::KIND_REPORT, 8'h00, 3'd5, 16'h0000, 1, 1'b1);
    plan_word(wcss_pkg::KIND_ARB,    8'h20, 3'd0, 16'h0000, 1, 1'b0);
    plan_word(wcss_pkg::KIND_ARB,    8'h30, 3'd0, 16'h0000, 1, 1'b0);
    plan_word(wcss_pkg::KIND_DECAY,  8'h00, 3'd0, 16'h0000, 1, 1'b1);
    plan_word(wcss_pkg::KIND_REPORT, 8'h00, 3'd7, 16'hFFFF, 1, 1'b1);
    plan_prio(64'h0101_FF01_0101_0100);
    plan_word(wcss_pkg::KIND_ARB,    8'hA0, 3'd0, 16'h0000, 1, 1'b0);  // extreme priorities
    plan_word(wcss_pkg::KIND_ARB,    8'hFF, 3'd0, 16'h0000, 1, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_priorities(plan[i].cfg_word);
      end else begin
        for (int r = 0; r < int'(plan[i].reps); r++)
          send_word(plan[i].kind, plan[i].mask, plan[i].chan, plan[i].nbytes,
                    plan[i].no_grant);
      end
    end

    // Random phases, each under its own idling pattern and priority table
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          phase_prio = {$urandom, $urandom};
        end
        1: begin
          send_idle_pct = 85; recv_stall_pct = 0;
          phase_prio = '1;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 85;
          phase_prio = {$urandom, $urandom} & 64'hFF00_FFFF_00FF_FF00;
        end
        default: begin
          send_idle_pct = 18; recv_stall_pct = 18;
          phase_prio = 64'h0101_0101_0101_0101;
        end
      endcase
      write_priorities(phase_prio);
      // long receiver hold-off while words keep coming, to back the block up
      if (ph == 0) holds_asked++;
      repeat (PhaseWords) random_word();
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("weighted_channel_send_scheduler verification clean");
    else
      $display("weighted_channel_send_scheduler verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wcss_pkg.sv
hw/rtl/wcss_cell.sv
hw/rtl/weighted_channel_send_scheduler.sv
tb/tb_weighted_channel_send_scheduler.sv
